>>> hdl/cos_pkg.sv
package cos_pkg;

  // time format
  localparam int unsigned TIME_W             = 64;
  localparam int unsigned TIME_FRAC_BITS_DEF = 32;

  // weights are unsigned Q0.16
  localparam int unsigned WGT_W = 16;

  // shared multiply-accumulate unit
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = WGT_W;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W   = TIME_W + WGT_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = WGT_W;
  localparam logic [WGT_W-1:0] WPS_RESET   = 16'd13107;
  localparam logic [WGT_W-1:0] LIMIT_RESET = 16'd55705;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEIGHT_PER_SECOND = 1'b0,
    CFG_WEIGHT_LIMIT      = 1'b1
  } cfg_idx_e;

  // tick packet constants
  localparam logic [7:0]  TICK_TAG  = 8'h54;
  localparam logic [7:0]  TICK_LEN  = 8'd14;
  localparam logic [31:0] SWAP_MARK = 32'h04030201;

  typedef struct packed {
    logic signed [TIME_W-1:0] now_time;
    logic                     has_packet;
    logic [7:0]               packet_length;
    logic [7:0]               packet_tag;
    logic [7:0]               packet_seq;
    logic [31:0]              order_mark;
    logic [TIME_W-1:0]        master_time_raw;
    logic signed [TIME_W-1:0] rx_stamp;
  } in_item_t;

  typedef struct packed {
    logic                     accepted;
    logic signed [TIME_W-1:0] offset;
  } tick_res_t;

  typedef struct packed {
    logic               en;
    logic               clear;
    logic               hi;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
    logic [WGT_W-1:0]   addend;
  } mac_op_t;

  function automatic logic [TIME_W-1:0] swap_bytes8(input logic [TIME_W-1:0] v);
    logic [TIME_W-1:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

  // signed subtract clamped to the 64-bit range
  function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    if ((a[TIME_W-1] != b[TIME_W-1]) && (d[TIME_W-1] != a[TIME_W-1])) begin
      d = a[TIME_W-1] ? {1'b1, {(TIME_W-1){1'b0}}} : {1'b0, {(TIME_W-1){1'b1}}};
    end
    return d;
  endfunction

endpackage

>>> hdl/cos_in_if.sv
interface cos_in_if;
  logic              valid;
  logic              ready;
  logic signed [63:0] now_time;
  logic              has_packet;
  logic [7:0]        packet_length;
  logic [7:0]        packet_tag;
  logic [7:0]        packet_seq;
  logic [31:0]       order_mark;
  logic [63:0]       master_time_raw;
  logic signed [63:0] rx_stamp;

  modport source (
    output valid, now_time, has_packet, packet_length, packet_tag, packet_seq,
           order_mark, master_time_raw, rx_stamp,
    input  ready
  );

  modport sink (
    input  valid, now_time, has_packet, packet_length, packet_tag, packet_seq,
           order_mark, master_time_raw, rx_stamp,
    output ready
  );
endinterface

>>> hdl/cos_out_if.sv
interface cos_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] offset_average;
  logic signed [63:0] offset_latest;
  logic               averaging_started;
  logic               packet_accepted;

  modport source (
    output valid, offset_average, offset_latest, averaging_started, packet_accepted,
    input  ready
  );

  modport sink (
    input  valid, offset_average, offset_latest, averaging_started, packet_accepted,
    output ready
  );
endinterface

>>> hdl/clock_offset_smoother_core.sv
// channel   dir  handshake      payload
// in_i      in   valid/ready    poll step: local time and optional tick packet
// out_o     out  valid/ready    average offset, latest offset, started, accepted
// cfg       in   cfg_we_i only  weight_per_second (0), weight_limit (1)
//
// a poll step runs through the transfer cycle, then decode, two passes of
// the 32x16 multiply-accumulate for the weight, clamp, two passes for the blend
// and a final update. the result is offered once the final update has loaded the
// output register, and the next step can be taken in that same cycle. the passes share one multiplier.
// reset clears the control state, not the datapath registers; the first step uses an elapsed time of 0.1 s.
// a result waits in the output register; the next step is taken meanwhile and
// holds in its final cycle only while the previous result is still not taken.
module clock_offset_smoother_core #(
  parameter int unsigned TIME_FRAC_BITS = cos_pkg::TIME_FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cos_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cos_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  cos_in_if.sink                             in_i,
  cos_out_if.source                          out_o
);
  import cos_pkg::*;

  // 0.1 s rounded to the time format
  localparam logic [TIME_W-1:0] FIRST_ELAPSED =
    ((64'd1 << TIME_FRAC_BITS) + 64'd5) / 64'd10;

  // sequencer states
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_PREP  = 8'b0000_0010,
    ST_WLO   = 8'b0000_0100,
    ST_WHI   = 8'b0000_1000,
    ST_CLAMP = 8'b0001_0000,
    ST_BLO   = 8'b0010_0000,
    ST_BHI   = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_e;

  state_e state_d, state_q;

  // configuration registers
  logic [WGT_W-1:0] wps_q, limit_q;

  // captured step and working registers
  in_item_t          item_q;
  logic [TIME_W-1:0] elapsed_q;
  logic [WGT_W-1:0]  w_q;
  logic [TIME_W-1:0] mag_q;
  logic              neg_q;

  // smoother state
  logic [TIME_W-1:0] prev_time_q;
  logic              prev_valid_q;
  logic [TIME_W-1:0] latest_q;
  logic [TIME_W-1:0] avg_q;
  logic              seeded_q;
  logic              accepted_q;

  // output register
  logic              out_valid_q;
  logic [TIME_W-1:0] out_avg_q, out_latest_q;
  logic              out_started_q, out_accepted_q;

  logic              in_xfer;
  logic              out_xfer;
  logic              out_free;
  tick_res_t         tick_res;
  mac_op_t           mac_op;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  w_raw;
  logic              elapsed_pos;
  logic [WGT_W-1:0]  w_clamped;
  logic              tgt_below;
  logic [TIME_W-1:0] step;
  logic [TIME_W-1:0] avg_next;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_valid_q && out_o.ready;
  // final cycle may load the output register once the last result is gone or is taken in that cycle
  assign out_free   = !out_valid_q || out_o.ready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wps_q   <= WPS_RESET;
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WEIGHT_PER_SECOND: wps_q   <= cfg_data_i;
        CFG_WEIGHT_LIMIT:      limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // packet check, sequence tracking and offset
  cos_tick u_tick (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (state_q == ST_PREP),
    .item_i (item_q),
    .res_o  (tick_res)
  );

  // operand selection for the shared multiply-accumulate
  always_comb begin
    mac_op = '0;
    case (state_q)
      ST_WLO: begin
        mac_op.en    = 1'b1;
        mac_op.clear = 1'b1;
        mac_op.a     = elapsed_q[MUL_A_W-1:0];
        mac_op.b     = wps_q;
      end
      ST_WHI: begin
        mac_op.en = 1'b1;
        mac_op.hi = 1'b1;
        mac_op.a  = elapsed_q[TIME_W-1:MUL_A_W];
        mac_op.b  = wps_q;
      end
      ST_BLO: begin
        // rounding term turns the floor into a ceiling when moving down
        mac_op.en     = 1'b1;
        mac_op.clear  = 1'b1;
        mac_op.a      = mag_q[MUL_A_W-1:0];
        mac_op.b      = w_q;
        mac_op.addend = neg_q ? {WGT_W{1'b1}} : '0;
      end
      ST_BHI: begin
        mac_op.en = 1'b1;
        mac_op.hi = 1'b1;
        mac_op.a  = mag_q[TIME_W-1:MUL_A_W];
        mac_op.b  = w_q;
      end
      default: ;
    endcase
  end

  cos_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .acc_o  (acc)
  );

  // weight = min(limit, elapsed * rate), zero for a non-positive elapsed time
  assign w_raw       = acc >> TIME_FRAC_BITS;
  assign elapsed_pos = !elapsed_q[TIME_W-1] && (elapsed_q != '0);
  always_comb begin
    if (!elapsed_pos) begin
      w_clamped = '0;
    end else if ((|w_raw[ACC_W-1:WGT_W]) || (w_raw[WGT_W-1:0] > limit_q)) begin
      w_clamped = limit_q;
    end else begin
      w_clamped = w_raw[WGT_W-1:0];
    end
  end

  assign tgt_below = $signed(latest_q) < $signed(avg_q);

  // blend step: (mag * w) / 65536, with the new average rounded down in both directions
  assign step     = acc[WGT_W +: TIME_W];
  assign avg_next = neg_q ? (avg_q - step) : (avg_q + step);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_xfer) state_d = ST_PREP;
      ST_PREP:  state_d = ST_WLO;
      ST_WLO:   state_d = ST_WHI;
      ST_WHI:   state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_BLO;
      ST_BLO:   state_d = ST_BHI;
      ST_BHI:   state_d = ST_FIN;
      ST_FIN:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control and smoother state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      prev_time_q  <= '0;
      prev_valid_q <= 1'b0;
      latest_q     <= '0;
      avg_q        <= '0;
      seeded_q     <= 1'b0;
      accepted_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PREP) begin
        prev_time_q  <= item_q.now_time;
        prev_valid_q <= 1'b1;
        accepted_q   <= tick_res.accepted;
        if (tick_res.accepted) begin
          latest_q <= tick_res.offset;
        end
      end
      if ((state_q == ST_FIN) && out_free) begin
        if (seeded_q) begin
          avg_q <= avg_next;
        end else if (latest_q != '0) begin
          // first nonzero offset seeds the average
          avg_q    <= latest_q;
          seeded_q <= 1'b1;
        end
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.now_time        <= in_i.now_time;
      item_q.has_packet      <= in_i.has_packet;
      item_q.packet_length   <= in_i.packet_length;
      item_q.packet_tag      <= in_i.packet_tag;
      item_q.packet_seq      <= in_i.packet_seq;
      item_q.order_mark      <= in_i.order_mark;
      item_q.master_time_raw <= in_i.master_time_raw;
      item_q.rx_stamp        <= in_i.rx_stamp;
    end
    if (state_q == ST_PREP) begin
      // elapsed time wraps modulo 2^64
      elapsed_q <= prev_valid_q ? (item_q.now_time - prev_time_q) : FIRST_ELAPSED;
    end
    if (state_q == ST_CLAMP) begin
      w_q   <= w_clamped;
      neg_q <= tgt_below;
      mag_q <= tgt_below ? (avg_q - latest_q) : (latest_q - avg_q);
    end
    if ((state_q == ST_FIN) && out_free) begin
      out_avg_q      <= seeded_q ? avg_next : latest_q;
      out_latest_q   <= latest_q;
      out_started_q  <= seeded_q || (latest_q != '0);
      out_accepted_q <= accepted_q;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.offset_average    = (seeded_q || out_started_q) ? out_avg_q : '0;
  assign out_o.offset_latest     = out_latest_q;
  assign out_o.averaging_started = out_started_q;
  assign out_o.packet_accepted   = out_accepted_q;
endmodule

>>> hdl/cos_mac.sv
module cos_mac (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cos_pkg::mac_op_t        op_i,
  output logic [cos_pkg::ACC_W-1:0] acc_o
);
  import cos_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  term;
  logic [ACC_W-1:0]  base;
  logic [ACC_W-1:0]  acc_d, acc_q;

  // 32x16 product placed at the low or the high word of the accumulator
  assign prod  = op_i.a * op_i.b;
  assign term  = op_i.hi ? {prod, {MUL_A_W{1'b0}}}
                         : {{(ACC_W-PROD_W){1'b0}}, prod};
  assign base  = op_i.clear ? {{(ACC_W-WGT_W){1'b0}}, op_i.addend} : acc_q;
  assign acc_d = base + term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (op_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;
endmodule

>>> hdl/cos_tick.sv
module cos_tick (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  cos_pkg::in_item_t  item_i,
  output cos_pkg::tick_res_t res_o
);
  import cos_pkg::*;

  logic [7:0]        held_seq_q;
  logic              seen_q;
  logic              is_tick;
  logic [7:0]        seq_diff;
  logic              ahead;
  logic [TIME_W-1:0] master;

  assign is_tick  = item_i.has_packet && (item_i.packet_length == TICK_LEN)
                    && (item_i.packet_tag == TICK_TAG);
  // ahead by a signed 8-bit difference of 1..127
  assign seq_diff = item_i.packet_seq - held_seq_q;
  assign ahead    = (seq_diff != 8'd0) && !seq_diff[7];
  assign master   = (item_i.order_mark == SWAP_MARK) ? swap_bytes8(item_i.master_time_raw)
                                                     : item_i.master_time_raw;

  assign res_o.accepted = is_tick && seen_q && ahead;
  assign res_o.offset   = sat_sub(master, item_i.rx_stamp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_seq_q <= '0;
      seen_q     <= 1'b0;
    end else if (en_i && is_tick && (!seen_q || ahead)) begin
      // first tick only sets the sequence; later ticks that are ahead update it
      held_seq_q <= item_i.packet_seq;
      seen_q     <= 1'b1;
    end
  end
endmodule
